### src/slwc_pkg.sv
// Package for the sound level window classifier: widths, reset values, codes.
package slwc_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned MAX_BLOCK   = 256;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned BS_W    = 9;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned PROD_W  = LEVEL_W + BS_W;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned BS_MAX  = (1 << BS_W) - 1;

  typedef enum logic [IDX_W-1:0] {
    REG_FUSSY_LEVEL      = 3'd0,
    REG_AGITATED_LEVEL   = 3'd1,
    REG_DISTRESSED_LEVEL = 3'd2,
    REG_BLOCK_SIZE       = 3'd3,
    REG_BLOCKS_PER_WIN   = 3'd4,
    REG_COUNT_THRESHOLD  = 3'd5,
    REG_DISTRESS_THRESH  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_QUIET      = 2'd0,
    VERDICT_FUSSY      = 2'd1,
    VERDICT_AGITATED   = 2'd2,
    VERDICT_DISTRESSED = 2'd3
  } verdict_e;

  localparam logic [LEVEL_W-1:0] FUSSY_LEVEL_RST      = 16'd800;
  localparam logic [LEVEL_W-1:0] AGITATED_LEVEL_RST   = 16'd1600;
  localparam logic [LEVEL_W-1:0] DISTRESSED_LEVEL_RST = 16'd2400;
  localparam logic [BS_W-1:0]    BLOCK_SIZE_RST       = 9'd100;
  localparam logic [CNT_W-1:0]   BLOCKS_PER_WIN_RST   = 8'd40;
  localparam logic [CNT_W-1:0]   COUNT_THRESHOLD_RST  = 8'd10;
  localparam logic [CNT_W-1:0]   DISTRESS_THRESH_RST  = 8'd5;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

### src/sound_level_window_classifier_core.sv
// Top level of the sound level window classifier.
//
// Input channel: in_valid_i / in_stall_o with one sample_i per item. Samples
// are summed into blocks of block_size; each finished block is graded
// against three levels (sum*16 > level*block_size), and after
// blocks_per_window blocks one verdict item leaves on the output channel
// out_valid_o / out_stall_i with verdict_o and last_block_sum_o.
// Configuration: write cfg_we_i with cfg_idx_i and cfg_data_i while idle.
// An item is taken every cycle while in_stall_o is low. A sample goes into
// an input register, is folded into the block state from there, and the
// verdict of the sample that closes a window is loaded into the output
// register. The level products are registered from the configuration, so
// the per-item path is one add and three compares.
// Reset clears the sum, the sample, block and level counters and the output
// valid, and loads the default levels and sizes. While a verdict waits under
// out_stall_i, samples that do not close a window are still taken; a sample
// that would close one is held in the input register and in_stall_o rises.
module sound_level_window_classifier_core #(
  parameter int unsigned SampleBits = slwc_pkg::SAMPLE_BITS,
  parameter int unsigned MaxBlock   = slwc_pkg::MAX_BLOCK
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [slwc_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [slwc_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [SampleBits-1:0]                 sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output slwc_pkg::verdict_e                    verdict_o,
  output logic [slwc_pkg::SUM_W-1:0]            last_block_sum_o
);
  import slwc_pkg::*;

  localparam int unsigned BsCap = (MaxBlock < BS_MAX) ? MaxBlock : BS_MAX;

  logic [LEVEL_W-1:0] fussy_q, agitated_q, distressed_q;
  logic [BS_W-1:0]    bs_q;
  logic [CNT_W-1:0]   bpw_q, cnt_thr_q, dis_thr_q;

  logic [BS_W-1:0]    bs_eff;
  logic [CNT_W-1:0]   bpw_eff;
  logic [PROD_W-1:0]  prod_fus_q, prod_agi_q, prod_dis_q;

  logic               in_valid_q;
  logic [SampleBits-1:0] sample_q;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [BS_W-1:0]    samples_q, samples_d;
  logic [CNT_W-1:0]   blocks_q, blocks_d;
  logic [CNT_W-1:0]   fus_cnt_q, fus_cnt_d;
  logic [CNT_W-1:0]   agi_cnt_q, agi_cnt_d;
  logic [CNT_W-1:0]   dis_cnt_q, dis_cnt_d;

  logic               out_valid_q;
  verdict_e           verdict_q, verdict_d;
  logic [SUM_W-1:0]   lbs_q;

  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_nx;
  logic [BS_W-1:0]    samp_nx;
  logic [CNT_W-1:0]   blocks_inc;
  logic [PROD_W-1:0]  sum16;
  logic               blk_end, win_end, blocked, adv, load, accept;
  logic               hit_dis, hit_agi, hit_fus;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fussy_q      <= FUSSY_LEVEL_RST;
      agitated_q   <= AGITATED_LEVEL_RST;
      distressed_q <= DISTRESSED_LEVEL_RST;
      bs_q         <= BLOCK_SIZE_RST;
      bpw_q        <= BLOCKS_PER_WIN_RST;
      cnt_thr_q    <= COUNT_THRESHOLD_RST;
      dis_thr_q    <= DISTRESS_THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FUSSY_LEVEL:      fussy_q      <= cfg_data_i[LEVEL_W-1:0];
        REG_AGITATED_LEVEL:   agitated_q   <= cfg_data_i[LEVEL_W-1:0];
        REG_DISTRESSED_LEVEL: distressed_q <= cfg_data_i[LEVEL_W-1:0];
        REG_BLOCK_SIZE:       bs_q         <= cfg_data_i[BS_W-1:0];
        REG_BLOCKS_PER_WIN:   bpw_q        <= cfg_data_i[CNT_W-1:0];
        REG_COUNT_THRESHOLD:  cnt_thr_q    <= cfg_data_i[CNT_W-1:0];
        REG_DISTRESS_THRESH:  dis_thr_q    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bs_eff = bs_q;
    if (bs_q == '0) begin
      bs_eff = BS_W'(1);
    end else if (bs_q > BS_W'(BsCap)) begin
      bs_eff = BS_W'(BsCap);
    end
    bpw_eff = (bpw_q == '0) ? CNT_W'(1) : bpw_q;
  end

  // level thresholds scaled by block size
  always_ff @(posedge clk_i) begin
    prod_fus_q <= PROD_W'(fussy_q) * PROD_W'(bs_eff);
    prod_agi_q <= PROD_W'(agitated_q) * PROD_W'(bs_eff);
    prod_dis_q <= PROD_W'(distressed_q) * PROD_W'(bs_eff);
  end

  assign sum_ext    = {1'b0, sum_q} + (SUM_W+1)'(sample_q);
  assign sum_nx     = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign samp_nx    = samples_q + 1'b1;
  assign blocks_inc = sat_inc(blocks_q);
  assign blk_end    = (samp_nx >= bs_eff);
  assign win_end    = blk_end && (blocks_inc >= bpw_eff);
  assign sum16      = PROD_W'({sum_nx, 4'b0000});
  assign hit_dis    = (sum16 > prod_dis_q);
  assign hit_agi    = (sum16 > prod_agi_q);
  assign hit_fus    = (sum16 > prod_fus_q);

  assign blocked    = win_end && out_valid_q && out_stall_i;
  assign adv        = in_valid_q && !blocked;
  assign load       = adv && win_end;
  assign in_stall_o = in_valid_q && blocked;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sum_d     = sum_nx;
    samples_d = samp_nx;
    blocks_d  = blocks_q;
    fus_cnt_d = fus_cnt_q;
    agi_cnt_d = agi_cnt_q;
    dis_cnt_d = dis_cnt_q;
    verdict_d = VERDICT_QUIET;
    if (blk_end) begin
      sum_d     = '0;
      samples_d = '0;
      blocks_d  = blocks_inc;
      if (hit_dis) begin
        dis_cnt_d = sat_inc(dis_cnt_q);
      end else if (hit_agi) begin
        agi_cnt_d = sat_inc(agi_cnt_q);
      end else if (hit_fus) begin
        fus_cnt_d = sat_inc(fus_cnt_q);
      end
      if (fus_cnt_d > cnt_thr_q) begin
        verdict_d = VERDICT_FUSSY;
      end else if (agi_cnt_d > cnt_thr_q) begin
        verdict_d = VERDICT_AGITATED;
      end else if (dis_cnt_d > dis_thr_q) begin
        verdict_d = VERDICT_DISTRESSED;
      end
      if (win_end) begin
        blocks_d  = '0;
        fus_cnt_d = '0;
        agi_cnt_d = '0;
        dis_cnt_d = '0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

  // block and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      samples_q <= '0;
      blocks_q  <= '0;
      fus_cnt_q <= '0;
      agi_cnt_q <= '0;
      dis_cnt_q <= '0;
    end else if (adv) begin
      sum_q     <= sum_d;
      samples_q <= samples_d;
      blocks_q  <= blocks_d;
      fus_cnt_q <= fus_cnt_d;
      agi_cnt_q <= agi_cnt_d;
      dis_cnt_q <= dis_cnt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
      lbs_q     <= sum_nx;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign last_block_sum_o = lbs_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(out_valid_q && out_stall_i))
    else $error("verdict loaded over a waiting item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+2)'(fus_cnt_q) + (CNT_W+2)'(agi_cnt_q) + (CNT_W+2)'(dis_cnt_q))
      <= (CNT_W+2)'(blocks_q))
    else $error("level counts exceed blocks in window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && blocks_q == '0 && samples_q == '0))
    else $error("window state not cleared after verdict");

endmodule
